[rtl/uv_sphere_quad_generator_top_assert.svh]
// Assertion macros for the UV-sphere quad generator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef UV_SPHERE_QUAD_GENERATOR_TOP_ASSERT_SVH
`define UV_SPHERE_QUAD_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define USQG_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("usqg assertion failed");

// Next-cycle implication.
`define USQG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("usqg assertion failed");

`endif

[rtl/usqg_pkg.sv]
// Shared types, constants and small functions of the UV-sphere quad generator.
// No dependencies.
package usqg_pkg;

	localparam int CNT_W   = 9;
	localparam int IDX_W   = 8;
	localparam int RAD_W   = 16;
	localparam int OUT_W   = 17;
	localparam int TRIG_W  = 32;
	localparam int QUO_W   = 33;
	localparam int INV_W   = 25;
	localparam int XR_W    = 18;
	localparam int SAT_W   = 24;
	localparam int TABLE_LEN = 24;
	localparam int MID_DEPTH = 8;
	localparam int OUT_DEPTH = 8;
	localparam int OUT_LIMIT = 65535;
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic [2:0] LAST_VTX = 3'd5;

	typedef enum logic [1:0] {
		REG_RING_COUNT    = 2'd0,
		REG_SEGMENT_COUNT = 2'd1,
		REG_SPHERE_RADIUS = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0]      ring_quo;
		logic [CNT_W-1:0] ring_rem;
		logic [INV_W-1:0] ring_inv;
		logic [CNT_W-1:0] ring_n;
		logic [QUO_W-1:0] seg_quo;
		logic [CNT_W-1:0] seg_rem;
		logic [INV_W-1:0] seg_inv;
		logic [CNT_W-1:0] seg_n;
	} div_consts_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_t0;
		logic signed [TRIG_W-1:0] sin_t0;
		logic signed [TRIG_W-1:0] cos_t1;
		logic signed [TRIG_W-1:0] sin_t1;
		logic signed [TRIG_W-1:0] cos_p0;
		logic signed [TRIG_W-1:0] sin_p0;
		logic signed [TRIG_W-1:0] cos_p1;
		logic signed [TRIG_W-1:0] sin_p1;
	} trig_set_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] pos_x;
		logic signed [OUT_W-1:0] pos_y;
		logic signed [OUT_W-1:0] pos_z;
		logic                    tex_u;
		logic                    tex_v;
		logic                    last_vertex;
	} vertex_t;

	function automatic logic signed [TRIG_W-1:0] atan_phase(input int i);
		logic signed [TRIG_W-1:0] a;
		case (i)
			0:  a = 32'sh20000000;
			1:  a = 32'sh12E4051E;
			2:  a = 32'sh09FB385B;
			3:  a = 32'sh051111D4;
			4:  a = 32'sh028B0D43;
			5:  a = 32'sh0145D7E1;
			6:  a = 32'sh00A2F61E;
			7:  a = 32'sh00517C55;
			8:  a = 32'sh0028BE53;
			9:  a = 32'sh00145F2F;
			10: a = 32'sh000A2F98;
			11: a = 32'sh000517CC;
			12: a = 32'sh00028BE6;
			13: a = 32'sh000145F3;
			14: a = 32'sh0000A2FA;
			15: a = 32'sh0000517D;
			16: a = 32'sh000028BE;
			17: a = 32'sh0000145F;
			18: a = 32'sh00000A30;
			19: a = 32'sh00000518;
			20: a = 32'sh0000028C;
			21: a = 32'sh00000146;
			22: a = 32'sh000000A3;
			23: a = 32'sh00000051;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Quad corner visited by each of the six vertices.
	function automatic logic [1:0] corner_of(input logic [2:0] v);
		logic [1:0] c;
		unique case (v)
			3'd0: c = 2'd0;
			3'd1: c = 2'd1;
			3'd2: c = 2'd3;
			3'd3: c = 2'd1;
			3'd4: c = 2'd2;
			3'd5: c = 2'd3;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > SAT_W'(OUT_LIMIT)) begin
			r = OUT_W'(OUT_LIMIT);
		end else if (v < -SAT_W'(OUT_LIMIT)) begin
			r = -OUT_W'(OUT_LIMIT);
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/uv_sphere_quad_generator_top.sv]
// Top level of the UV-sphere quad generator: registers, divider setup, front, queues, back.
// Depends on usqg_pkg, usqg_recip, usqg_front, usqg_fifo, usqg_back and the assert header.
//
//  Channel  Handshake          Payload
//  input    push / full        ring_index, segment_index
//  result   empty / pop        pos_*, normal_*, tex_u, tex_v, last_vertex
//  config   wr_en              wr_index, wr_data
//
// An item is taken every cycle while credit lasts and the dividers are idle; each item yields
// six vertices, one a cycle from the back sequencer while output credit lasts.
// After reset and after each count write the reciprocal dividers run with full high.
// Requests outside the ring or segment count are taken and dropped.
`include "uv_sphere_quad_generator_top_assert.svh"

module uv_sphere_quad_generator_top #(
	parameter int CORDIC_STEPS  = 16,
	parameter int MAX_DIVISIONS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         ring_index,
	input  logic [7:0]         segment_index,
	output logic               empty,
	input  logic               pop,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic signed [16:0] normal_x,
	output logic signed [16:0] normal_y,
	output logic signed [16:0] normal_z,
	output logic               tex_u,
	output logic               tex_v,
	output logic               last_vertex,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [15:0]        wr_data
);
	localparam int CRW = $clog2(usqg_pkg::MID_DEPTH + 1);
	localparam int CW  = usqg_pkg::CNT_W;

	logic [CW-1:0]                ring_count_q, segment_count_q;
	logic [usqg_pkg::RAD_W-1:0]   sphere_radius_q;
	logic [CW-1:0]                rings, segs;
	logic                         start;
	logic                         busy_r, busy_s;
	logic [usqg_pkg::QUO_W-1:0]   quo_r, quo_s;
	logic [CW-1:0]                rem_r, rem_s;
	logic [CW:0]                  rem_sum;
	usqg_pkg::div_consts_t        consts;
	logic                         div_busy;
	logic [CRW-1:0]               credit_q;
	logic                         accept, entered;
	logic                         f_valid;
	usqg_pkg::trig_set_t          f_data, mid_head;
	logic                         mid_empty, mid_pop;
	logic                         v_valid;
	usqg_pkg::vertex_t            v_data, out_head;
	logic                         out_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q    <= 9'd16;
			segment_count_q <= 9'd16;
			sphere_radius_q <= 16'd256;
		end else if (wr_en) begin
			unique case (wr_index)
				usqg_pkg::REG_RING_COUNT:    ring_count_q    <= wr_data[CW-1:0];
				usqg_pkg::REG_SEGMENT_COUNT: segment_count_q <= wr_data[CW-1:0];
				usqg_pkg::REG_SPHERE_RADIUS: sphere_radius_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ring_count_q == '0) begin
			rings = CW'(1);
		end else if (int'(ring_count_q) > MAX_DIVISIONS) begin
			rings = CW'(MAX_DIVISIONS);
		end else begin
			rings = ring_count_q;
		end
		if (segment_count_q == '0) begin
			segs = CW'(1);
		end else if (int'(segment_count_q) > MAX_DIVISIONS) begin
			segs = CW'(MAX_DIVISIONS);
		end else begin
			segs = segment_count_q;
		end
	end

	assign start = wr_en && ((wr_index == usqg_pkg::REG_RING_COUNT)
		|| (wr_index == usqg_pkg::REG_SEGMENT_COUNT));

	usqg_recip u_recip_ring (
		.clk(clk), .arst_n(arst_n), .start(start), .divisor(rings),
		.busy(busy_r), .quo(quo_r), .rem(rem_r)
	);

	usqg_recip u_recip_seg (
		.clk(clk), .arst_n(arst_n), .start(start), .divisor(segs),
		.busy(busy_s), .quo(quo_s), .rem(rem_s)
	);

	// Half of the full-turn quotient gives the half-turn quotient used for latitude.
	assign rem_sum         = {1'b0, rem_r} + {1'b0, rings};
	assign consts.ring_quo = quo_r[usqg_pkg::QUO_W-1:1];
	assign consts.ring_rem = quo_r[0] ? rem_sum[CW:1] : {1'b0, rem_r[CW-1:1]};
	assign consts.ring_inv = quo_r[usqg_pkg::QUO_W-1:8];
	assign consts.ring_n   = rings;
	assign consts.seg_quo  = quo_s;
	assign consts.seg_rem  = rem_s;
	assign consts.seg_inv  = quo_s[usqg_pkg::QUO_W-1:8];
	assign consts.seg_n    = segs;

	assign div_busy = busy_r || busy_s;
	assign full     = div_busy || (credit_q == '0);
	assign accept   = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CRW'(usqg_pkg::MID_DEPTH);
		end else if (entered && !mid_pop) begin
			credit_q <= credit_q - 1'b1;
		end else if (mid_pop && !entered) begin
			credit_q <= credit_q + 1'b1;
		end
	end

	usqg_front #(.STEPS(CORDIC_STEPS)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept),
		.ring_index(ring_index), .segment_index(segment_index),
		.rings(rings), .segs(segs), .consts(consts),
		.entered(entered), .out_valid(f_valid), .out_data(f_data)
	);

	usqg_fifo #(.WIDTH($bits(usqg_pkg::trig_set_t)), .DEPTH(usqg_pkg::MID_DEPTH)) u_mid (
		.clk(clk), .arst_n(arst_n), .push(f_valid), .wdata(f_data),
		.pop(mid_pop), .rdata(mid_head), .empty(mid_empty)
	);

	usqg_back u_back (
		.clk(clk), .arst_n(arst_n), .head(mid_head), .head_empty(mid_empty),
		.head_pop(mid_pop), .radius(sphere_radius_q), .out_release(out_pop),
		.vert_valid(v_valid), .vert_data(v_data)
	);

	assign out_pop = pop && !empty;

	usqg_fifo #(.WIDTH($bits(usqg_pkg::vertex_t)), .DEPTH(usqg_pkg::OUT_DEPTH)) u_out (
		.clk(clk), .arst_n(arst_n), .push(v_valid), .wdata(v_data),
		.pop(out_pop), .rdata(out_head), .empty(empty)
	);

	assign pos_x       = out_head.pos_x;
	assign pos_y       = out_head.pos_y;
	assign pos_z       = out_head.pos_z;
	assign normal_x    = out_head.pos_x;
	assign normal_y    = out_head.pos_y;
	assign normal_z    = out_head.pos_z;
	assign tex_u       = out_head.tex_u;
	assign tex_v       = out_head.tex_v;
	assign last_vertex = out_head.last_vertex;

	`USQG_ASSERT_IMPLIES(a_credit_bound, 1'b1, credit_q <= CRW'(usqg_pkg::MID_DEPTH))
	`USQG_ASSERT_IMPLIES(a_mid_pop_nonempty, mid_pop, !mid_empty)
	`USQG_ASSERT_NEXT(a_full_after_count_write, start, full)
endmodule

[rtl/usqg_recip.sv]
// Restoring divider that forms floor(2^32 / n) and its remainder, one bit a cycle.
// Depends on usqg_pkg.
module usqg_recip (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [usqg_pkg::CNT_W-1:0]     divisor,
	output logic                           busy,
	output logic [usqg_pkg::QUO_W-1:0]     quo,
	output logic [usqg_pkg::CNT_W-1:0]     rem
);
	localparam int CW = $clog2(usqg_pkg::QUO_W);

	logic                          run_q;
	logic [CW-1:0]                 cnt_q;
	logic [usqg_pkg::CNT_W-1:0]    rem_q;
	logic [usqg_pkg::QUO_W-1:0]    quo_q;
	logic [usqg_pkg::CNT_W:0]      trial;
	logic                          ge;

	// The dividend is a one followed by 32 zeros.
	assign trial = {rem_q, (cnt_q == '0)};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b1;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? usqg_pkg::CNT_W'(trial - {1'b0, divisor}) : trial[usqg_pkg::CNT_W-1:0];
			quo_q <= {quo_q[usqg_pkg::QUO_W-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(usqg_pkg::QUO_W - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	assign busy = run_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

[rtl/usqg_cordic.sv]
// Fully pipelined rotation-mode CORDIC lane: 32-bit phase in, Q2.30 cos and sin out.
// Depends on usqg_pkg.
module usqg_cordic #(
	parameter int STEPS = 16
) (
	input  logic                                  clk,
	input  logic [31:0]                           phase,
	output logic signed [usqg_pkg::TRIG_W-1:0]    cos_out,
	output logic signed [usqg_pkg::TRIG_W-1:0]    sin_out
);
	logic signed [usqg_pkg::TRIG_W-1:0] x_q [STEPS+1];
	logic signed [usqg_pkg::TRIG_W-1:0] y_q [STEPS+1];
	logic signed [usqg_pkg::TRIG_W-1:0] z_q [STEPS+1];
	logic [1:0]                         quad_q [STEPS+1];

	always_ff @(posedge clk) begin
		x_q[0]    <= usqg_pkg::CORDIC_GAIN;
		y_q[0]    <= '0;
		z_q[0]    <= {2'b00, phase[29:0]};
		quad_q[0] <= phase[31:30];
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			quad_q[i+1] <= quad_q[i];
			if (!z_q[i][usqg_pkg::TRIG_W-1]) begin
				x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] - usqg_pkg::atan_phase(i);
			end else begin
				x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] + usqg_pkg::atan_phase(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (quad_q[STEPS])
			2'd0: begin
				cos_out <= x_q[STEPS];
				sin_out <= y_q[STEPS];
			end
			2'd1: begin
				cos_out <= -y_q[STEPS];
				sin_out <= x_q[STEPS];
			end
			2'd2: begin
				cos_out <= -x_q[STEPS];
				sin_out <= -y_q[STEPS];
			end
			default: begin
				cos_out <= y_q[STEPS];
				sin_out <= -x_q[STEPS];
			end
		endcase
	end
endmodule

[rtl/usqg_front.sv]
// Front part: range check, four angle phases by reciprocal multiply, four CORDIC lanes.
// Depends on usqg_pkg and usqg_cordic.
module usqg_front #(
	parameter int STEPS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [usqg_pkg::IDX_W-1:0]       ring_index,
	input  logic [usqg_pkg::IDX_W-1:0]       segment_index,
	input  logic [usqg_pkg::CNT_W-1:0]       rings,
	input  logic [usqg_pkg::CNT_W-1:0]       segs,
	input  usqg_pkg::div_consts_t            consts,
	output logic                             entered,
	output logic                             out_valid,
	output usqg_pkg::trig_set_t              out_data
);
	localparam int LAT = STEPS + 2;
	localparam int KW  = usqg_pkg::CNT_W;
	localparam int XW  = usqg_pkg::XR_W;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [LAT-1:0]            cv_q;
	logic [KW-1:0]             k_s1 [4];
	logic [31:0]               kq_s2 [4], kq_s3 [4], kq_s4 [4], kq_s5 [4];
	logic [XW-1:0]             x_s2 [4], x_s3 [4], x_s4 [4];
	logic [KW-1:0]             e_s3 [4], e_s4 [4], e_s5 [4];
	logic [XW-1:0]             en_s4 [4];
	logic                      corr_s5 [4];
	logic [31:0]               phase_s6 [4];
	logic signed [usqg_pkg::TRIG_W-1:0] cos_l [4], sin_l [4];

	assign entered = accept && ({1'b0, ring_index} < rings)
		&& ({1'b0, segment_index} < segs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			cv_q <= '0;
		end else begin
			v_s1 <= entered;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			cv_q <= {cv_q[LAT-2:0], v_s6};
		end
	end

	always_ff @(posedge clk) begin
		k_s1[0] <= {1'b0, ring_index};
		k_s1[1] <= {1'b0, ring_index} + 1'b1;
		k_s1[2] <= {1'b0, segment_index};
		k_s1[3] <= {1'b0, segment_index} + 1'b1;
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [usqg_pkg::QUO_W-1:0]   quo;
		logic [KW-1:0]                rem;
		logic [KW-1:0]                n;
		logic [usqg_pkg::INV_W-1:0]   inv;
		logic [KW+usqg_pkg::QUO_W-1:0] kq_full;
		logic [XW+usqg_pkg::INV_W-1:0] xi_full;
		logic [XW-1:0]                diff;

		assign quo = (l < 2) ? {1'b0, consts.ring_quo} : consts.seg_quo;
		assign rem = (l < 2) ? consts.ring_rem : consts.seg_rem;
		assign n   = (l < 2) ? consts.ring_n : consts.seg_n;
		assign inv = (l < 2) ? consts.ring_inv : consts.seg_inv;

		assign kq_full = {{usqg_pkg::QUO_W{1'b0}}, k_s1[l]} * {{KW{1'b0}}, quo};
		assign xi_full = {{usqg_pkg::INV_W{1'b0}}, x_s2[l]} * {{XW{1'b0}}, inv};
		assign diff    = x_s4[l] - en_s4[l];

		always_ff @(posedge clk) begin
			kq_s2[l]    <= kq_full[31:0];
			x_s2[l]     <= {{(XW-KW){1'b0}}, k_s1[l]} * {{(XW-KW){1'b0}}, rem};
			kq_s3[l]    <= kq_s2[l];
			x_s3[l]     <= x_s2[l];
			e_s3[l]     <= xi_full[24+KW-1:24];
			kq_s4[l]    <= kq_s3[l];
			x_s4[l]     <= x_s3[l];
			e_s4[l]     <= e_s3[l];
			en_s4[l]    <= {{(XW-KW){1'b0}}, e_s3[l]} * {{(XW-KW){1'b0}}, n};
			kq_s5[l]    <= kq_s4[l];
			e_s5[l]     <= e_s4[l];
			corr_s5[l]  <= diff >= {{(XW-KW){1'b0}}, n};
			phase_s6[l] <= kq_s5[l] + {{(32-KW){1'b0}}, e_s5[l]}
				+ {31'b0, corr_s5[l]};
		end

		usqg_cordic #(.STEPS(STEPS)) u_cordic (
			.clk     (clk),
			.phase   (phase_s6[l]),
			.cos_out (cos_l[l]),
			.sin_out (sin_l[l])
		);
	end

	assign out_valid       = cv_q[LAT-1];
	assign out_data.cos_t0 = cos_l[0];
	assign out_data.sin_t0 = sin_l[0];
	assign out_data.cos_t1 = cos_l[1];
	assign out_data.sin_t1 = sin_l[1];
	assign out_data.cos_p0 = cos_l[2];
	assign out_data.sin_p0 = sin_l[2];
	assign out_data.cos_p1 = cos_l[3];
	assign out_data.sin_p1 = sin_l[3];
endmodule

[rtl/usqg_fifo.sv]
// Small register queue with one write and one read port; the caller keeps it from overflowing.
// No dependencies.
module usqg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rd_q];
	assign empty = (cnt_q == '0);
endmodule

[rtl/usqg_back.sv]
// Back part: walks the six vertices of a quad and scales corners by the radius.
// Depends on usqg_pkg.
module usqg_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  usqg_pkg::trig_set_t            head,
	input  logic                           head_empty,
	output logic                           head_pop,
	input  logic [usqg_pkg::RAD_W-1:0]     radius,
	input  logic                           out_release,
	output logic                           vert_valid,
	output usqg_pkg::vertex_t              vert_data
);
	localparam int OCW = $clog2(usqg_pkg::OUT_DEPTH + 1);

	logic [2:0]        vtx_q;
	logic [OCW-1:0]    ocred_q;
	logic              issue;
	logic [1:0]        corner;
	logic              use_t1, use_p1;
	logic signed [31:0] st, ct, cp, sp;
	logic signed [16:0] r;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [2:0]         tag_s1, tag_s2, tag_s3;
	logic signed [63:0] mx_s1, mz_s1;
	logic signed [48:0] py_s1;
	logic signed [33:0] mx_s2, mz_s2;
	logic signed [18:0] y_s2, y_s3;
	logic signed [50:0] px_s3, pz_s3;
	usqg_pkg::vertex_t  vert_s4;

	logic signed [63:0] mx_rnd, mz_rnd;
	logic signed [48:0] py_rnd;
	logic signed [50:0] px_rnd, pz_rnd;

	assign issue    = !head_empty && (ocred_q != '0);
	assign head_pop = issue && (vtx_q == usqg_pkg::LAST_VTX);
	assign corner   = usqg_pkg::corner_of(vtx_q);
	assign use_t1   = corner[1];
	assign use_p1   = (corner == 2'd1) || (corner == 2'd2);
	assign st       = use_t1 ? head.sin_t1 : head.sin_t0;
	assign ct       = use_t1 ? head.cos_t1 : head.cos_t0;
	assign cp       = use_p1 ? head.cos_p1 : head.cos_p0;
	assign sp       = use_p1 ? head.sin_p1 : head.sin_p0;
	assign r        = $signed({1'b0, radius});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_q   <= '0;
			ocred_q <= OCW'(usqg_pkg::OUT_DEPTH);
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			if (issue) begin
				vtx_q <= (vtx_q == usqg_pkg::LAST_VTX) ? '0 : vtx_q + 1'b1;
			end
			if (issue && !out_release) begin
				ocred_q <= ocred_q - 1'b1;
			end else if (out_release && !issue) begin
				ocred_q <= ocred_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign mx_rnd = mx_s1 + 64'sd536870912;
	assign mz_rnd = mz_s1 + 64'sd536870912;
	assign py_rnd = py_s1 + 49'sd536870912;
	assign px_rnd = px_s3 + 51'sd536870912;
	assign pz_rnd = pz_s3 + 51'sd536870912;

	always_ff @(posedge clk) begin
		mx_s1  <= st * cp;
		mz_s1  <= st * sp;
		py_s1  <= r * ct;
		tag_s1 <= {corner[1], use_p1, vtx_q == usqg_pkg::LAST_VTX};
		mx_s2  <= mx_rnd[63:30];
		mz_s2  <= mz_rnd[63:30];
		y_s2   <= py_rnd[48:30];
		tag_s2 <= tag_s1;
		px_s3  <= r * mx_s2;
		pz_s3  <= r * mz_s2;
		y_s3   <= y_s2;
		tag_s3 <= tag_s2;
		vert_s4.pos_x       <= usqg_pkg::sat_out({{3{px_rnd[50]}}, px_rnd[50:30]});
		vert_s4.pos_y       <= usqg_pkg::sat_out({{5{y_s3[18]}}, y_s3});
		vert_s4.pos_z       <= usqg_pkg::sat_out({{3{pz_rnd[50]}}, pz_rnd[50:30]});
		vert_s4.tex_u       <= tag_s3[2];
		vert_s4.tex_v       <= tag_s3[1];
		vert_s4.last_vertex <= tag_s3[0];
	end

	assign vert_valid = v_s4;
	assign vert_data  = vert_s4;
endmodule

[tb/uv_sphere_quad_generator_checker.sv]
`timescale 1ns / 100ps
// Checker for the UV-sphere quad generator: watches the register, request and vertex ports,
// predicts the six vertices of every accepted in-range quad and compares them in order.
// Depends on usqg_pkg for the register index names.
module uv_sphere_quad_generator_checker #(
	parameter int CORDIC_STEPS  = 16,
	parameter int MAX_DIVISIONS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [7:0]         ring_index,
	input  logic [7:0]         segment_index,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [16:0] pos_x,
	input  logic signed [16:0] pos_y,
	input  logic signed [16:0] pos_z,
	input  logic signed [16:0] normal_x,
	input  logic signed [16:0] normal_y,
	input  logic signed [16:0] normal_z,
	input  logic               tex_u,
	input  logic               tex_v,
	input  logic               last_vertex,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [15:0]        wr_data,
	output int                 pending,
	output int                 errors
);
	typedef struct {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic signed [16:0] z;
		logic               u;
		logic               v;
		logic               last;
	} vertex_exp_t;

	localparam longint ATAN_TAB [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	logic [8:0]  rings_reg;
	logic [8:0]  segs_reg;
	logic [15:0] radius_reg;
	vertex_exp_t vertex_q [$];

	function automatic longint rnd30(input longint v);
		return (v + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic longint clip(input longint v);
		if (v > 65535)
			return 65535;
		if (v < -65535)
			return -65535;
		return v;
	endfunction

	function automatic int unsigned eff(input logic [8:0] c);
		if (c == 0)
			return 1;
		if (c > MAX_DIVISIONS)
			return MAX_DIVISIONS;
		return c;
	endfunction

	task automatic sincos(input logic [31:0] ph, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = longint'(ph[29:0]);
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TAB[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TAB[i];
			end
		end
		case (ph[31:30])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic predict_quad(input logic [7:0] j, input logic [7:0] i);
		int unsigned nr, ns;
		longint unsigned jj, ii;
		longint ct [2], st [2], cp [2], sp [2];
		longint r;
		vertex_exp_t c [4];
		int order [6] = '{0, 1, 3, 1, 2, 3};
		int th, ph;
		nr = eff(rings_reg);
		ns = eff(segs_reg);
		jj = j;
		ii = i;
		r = radius_reg;
		if (jj >= nr || ii >= ns)
			return;
		for (int k = 0; k < 2; k++) begin
			sincos(32'(((jj + k) << 31) / nr), ct[k], st[k]);
			sincos(32'(((ii + k) << 32) / ns), cp[k], sp[k]);
		end
		for (int k = 0; k < 4; k++) begin
			th = (k >= 2) ? 1 : 0;
			ph = (k == 1 || k == 2) ? 1 : 0;
			c[k].x = 17'(clip(rnd30(r * rnd30(st[th] * cp[ph]))));
			c[k].y = 17'(clip(rnd30(r * ct[th])));
			c[k].z = 17'(clip(rnd30(r * rnd30(st[th] * sp[ph]))));
			c[k].u = (k >= 2);
			c[k].v = (k == 1 || k == 2);
			c[k].last = 1'b0;
		end
		for (int k = 0; k < 6; k++) begin
			vertex_exp_t e;
			e = c[order[k]];
			e.last = (k == 5);
			vertex_q = {vertex_q, e};
		end
	endtask

	assign pending = vertex_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rings_reg <= 9'd16;
			segs_reg <= 9'd16;
			radius_reg <= 16'd256;
			errors <= 0;
		end else begin
			if (wr_en) begin
				case (usqg_pkg::cfg_reg_t'(wr_index))
					usqg_pkg::REG_RING_COUNT: rings_reg <= wr_data[8:0];
					usqg_pkg::REG_SEGMENT_COUNT: segs_reg <= wr_data[8:0];
					usqg_pkg::REG_SPHERE_RADIUS: radius_reg <= wr_data;
					default: ;
				endcase
			end
			if (push && !full)
				predict_quad(ring_index, segment_index);
			if (pop && !empty) begin
				if (vertex_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected vertex at %0t", $realtime);
					errors <= errors + 1;
				end else begin
					vertex_exp_t e;
					e = vertex_q.pop_front();
					if (pos_x !== e.x || pos_y !== e.y || pos_z !== e.z || normal_x !== e.x
							|| normal_y !== e.y || normal_z !== e.z || tex_u !== e.u
							|| tex_v !== e.v || last_vertex !== e.last) begin
						if (errors < 10)
							$display({"vertex mismatch: exp pos %0d %0d %0d uv %b%b last %b,",
								" got pos %0d %0d %0d nrm %0d %0d %0d uv %b%b last %b"},
								e.x, e.y, e.z, e.u, e.v, e.last, pos_x, pos_y, pos_z,
								normal_x, normal_y, normal_z, tex_u, tex_v, last_vertex);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

[tb/tb_uv_sphere_quad_generator_top.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for the UV-sphere quad generator: sends quad requests under several
// register settings and idling patterns. Depends on usqg_pkg, the block and its checker.
module tb_uv_sphere_quad_generator_top;
	localparam int CYCLE_LIMIT = 300000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] ring_index = '0;
	logic [7:0] segment_index = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [16:0] pos_x, pos_y, pos_z, normal_x, normal_y, normal_z;
	logic tex_u, tex_v, last_vertex;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = '0;
	logic [15:0] wr_data = '0;
	int pending, errors;
	int send_idle = 0;
	int recv_idle = 0;
	logic hold_req = 1'b0;
	logic holding = 1'b0;
	int cycles = 0;
	int rings_now = 16;
	int segs_now = 16;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	uv_sphere_quad_generator_top dut (.*);
	uv_sphere_quad_generator_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk)
		pop <= !holding && ($urandom_range(99) >= recv_idle);

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				holding = 1'b1;
				repeat (400) @(posedge clk);
				holding = 1'b0;
				hold_req = 1'b0;
			end
		end
	end

	task automatic send_quad(input logic [7:0] j, input logic [7:0] i);
		logic ok;
		int gap;
		ring_index <= j;
		segment_index <= i;
		push <= 1'b1;
		do begin
			@(negedge clk);
			ok = !full;
			@(posedge clk);
		end while (!ok);
		gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input usqg_pkg::cfg_reg_t idx, input logic [15:0] val);
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == usqg_pkg::REG_RING_COUNT)
			rings_now = (val[8:0] == 0) ? 1 : (val[8:0] > 256) ? 256 : val[8:0];
		if (idx == usqg_pkg::REG_SEGMENT_COUNT)
			segs_now = (val[8:0] == 0) ? 1 : (val[8:0] > 256) ? 256 : val[8:0];
	endtask

	task automatic set_sphere(input logic [15:0] rc, input logic [15:0] sc,
			input logic [15:0] rad);
		write_reg(usqg_pkg::REG_RING_COUNT, rc);
		write_reg(usqg_pkg::REG_SEGMENT_COUNT, sc);
		write_reg(usqg_pkg::REG_SPHERE_RADIUS, rad);
	endtask

	initial begin
		logic [15:0] rc, sc;
		logic [7:0] j, i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_quad(0, 0);
		send_quad(15, 15);
		send_quad(16, 0);
		send_quad(0, 16);
		send_quad(255, 255);
		send_quad(7, 3);
		set_sphere(1, 1, 0);
		send_quad(0, 0);
		send_quad(1, 0);
		set_sphere(0, 0, 16'hFFFF);
		send_quad(0, 0);
		send_quad(0, 1);
		set_sphere(16'h01FF, 256, 16'hFFFF);
		send_quad(255, 255);
		send_quad(0, 255);
		send_quad(255, 0);
		send_quad(128, 64);
		send_quad(170, 85);
		send_quad(85, 170);
		set_sphere(3, 5, 16'h0180);
		send_quad(2, 4);
		send_quad(1, 2);

		for (int phase = 0; phase < 6; phase++) begin
			send_idle = (phase < 2) ? 12 : (phase < 4) ? 75 : 0;
			recv_idle = (phase < 2) ? 75 : (phase < 4) ? 12 : 0;
			case (phase)
				0: begin rc = 256; sc = 256; end
				1: begin rc = 0; sc = 16'h01FF; end
				2: begin rc = 1; sc = 2; end
				default: begin
					rc = 16'($urandom_range(1, 256));
					sc = 16'($urandom_range(1, 256));
				end
			endcase
			set_sphere(rc, sc, (phase == 2) ? 16'hFFFF : 16'($urandom));
			if (phase == 4)
				hold_req = 1'b1;
			for (int n = 0; n < 60; n++) begin
				if ($urandom_range(99) < 88) begin
					j = 8'($urandom_range(rings_now - 1));
					i = 8'($urandom_range(segs_now - 1));
				end else begin
					j = 8'($urandom_range(255));
					i = 8'($urandom_range(255));
				end
				send_quad(j, i);
			end
		end

		push <= 1'b0;
		@(posedge clk);
		while (pending != 0 || hold_req)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl
rtl/usqg_pkg.sv
rtl/usqg_recip.sv
rtl/usqg_cordic.sv
rtl/usqg_front.sv
rtl/usqg_fifo.sv
rtl/usqg_back.sv
rtl/uv_sphere_quad_generator_top.sv
tb/uv_sphere_quad_generator_checker.sv
tb/tb_uv_sphere_quad_generator_top.sv
